// ----- design/mtg_pkg.sv -----
`timescale 1ns / 1ps
package mtg_pkg;

    localparam int WORD_W          = 32;
    localparam int STATE_DEPTH     = 624;
    localparam int TWIST_OFFSET    = 397;
    localparam int KEY_MAX_DEFAULT = 16;
    localparam int IDX_W           = $clog2(STATE_DEPTH);

    localparam logic [WORD_W-1:0] TWIST_MATRIX  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS      = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B      = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C      = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
    localparam logic [WORD_W-1:0] KEY_MULT_A    = 32'd1664525;
    localparam logic [WORD_W-1:0] KEY_MULT_B    = 32'd1566083941;
    localparam logic [WORD_W-1:0] KEY_BASE_SEED = 32'd19650218;
    localparam logic [WORD_W-1:0] DEFAULT_SEED  = 32'd5489;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_GENERATE   = 2'd0,
        OP_SEED_VALUE = 2'd1,
        OP_PUSH_KEY   = 2'd2,
        OP_SEED_KEY   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_KEY_MIX,
        ST_KEY_FINISH,
        ST_ALIGN,
        ST_GEN
    } t_state;

    typedef struct packed {
        logic  shift;
        t_word word;
    } t_ring_ctl;

    typedef struct packed {
        t_word head;
        t_word next;
        t_word far;
    } t_ring_taps;

    typedef struct packed {
        logic  valid;
        t_word word;
    } t_gen_push;

    function automatic t_word fold30(input t_word x);
        return x ^ (x >> 30);
    endfunction

    function automatic t_word mul32(input t_word a, input t_word b);
        t_word p;
        p = a * b;
        return p;
    endfunction

    function automatic t_word temper(input t_word x);
        t_word y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic t_word twist(input t_word head, input t_word next, input t_word far);
        t_word y;
        y = (head & HIGH_BIT) | (next & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
    endfunction

endpackage

// ----- design/mtg_in_if.sv -----
`timescale 1ns / 1ps
interface mtg_in_if import mtg_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    t_word       value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

// ----- design/mtg_out_if.sv -----
`timescale 1ns / 1ps
interface mtg_out_if import mtg_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// ----- design/mtg_cell.sv -----
`timescale 1ns / 1ps
module mtg_cell
    import mtg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_word i_d,
    output t_word o_q
);

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

// ----- design/mtg_ring.sv -----
`timescale 1ns / 1ps
module mtg_ring
    import mtg_pkg::*;
(
    input  logic       i_clk,
    input  t_ring_ctl  i_ctl,
    output t_ring_taps o_taps
);

    t_word w_q [STATE_DEPTH];

    // cell 0 is the oldest word, new words enter at the tail
    for (genvar k = 0; k < STATE_DEPTH; k++) begin : g_cell
        t_word w_d;
        if (k == STATE_DEPTH - 1) begin : g_tail
            assign w_d = i_ctl.word;
        end else begin : g_body
            assign w_d = w_q[k + 1];
        end
        mtg_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    assign o_taps.head = w_q[0];
    assign o_taps.next = w_q[1];
    assign o_taps.far  = w_q[TWIST_OFFSET];

endmodule

// ----- design/mtg_key_store.sv -----
`timescale 1ns / 1ps
module mtg_key_store
    import mtg_pkg::*;
#(
    parameter  int KEY_MAX = KEY_MAX_DEFAULT,
    localparam int KAW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [KAW-1:0] i_waddr,
    input  t_word          i_wdata,
    input  logic [KAW-1:0] i_raddr,
    output t_word          o_rdata
);

    t_word r_mem [KEY_MAX];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/mtg_seq.sv -----
`timescale 1ns / 1ps
module mtg_seq
    import mtg_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_opcode    i_opcode,
    input  t_word      i_value,
    input  t_ring_taps i_taps,
    output logic       o_idle,
    output t_ring_ctl  o_ring,
    output t_gen_push  o_gen
);

    localparam int KCW = $clog2(KEY_MAX + 1);
    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(STATE_DEPTH - 1);
    localparam logic [IDX_W-1:0] FINISH_LAST = IDX_W'(STATE_DEPTH - 2);

    t_state           r_state,       n_state;
    logic             r_seeded,      n_seeded;
    logic             r_gen_pending, n_gen_pending;
    logic             r_key_mode,    n_key_mode;
    logic             r_first,       n_first;
    logic             r_phase,       n_phase;
    logic [IDX_W-1:0] r_cnt,         n_cnt;
    logic [IDX_W-1:0] r_idx,         n_idx;
    t_word            r_prev,        n_prev;
    t_word            r_prod,        n_prod;
    logic [KCW-1:0]   r_key_count,   n_key_count;
    logic [KCW-1:0]   r_key_len,     n_key_len;
    logic             r_key_zero,    n_key_zero;
    logic [KAW-1:0]   r_j,           n_j;

    logic             w_key_we;
    t_word            w_key_rdata;
    logic             w_start_seed;
    t_word            w_seed_word;
    t_word            w_twist;
    t_word            w_mul_const;
    t_word            w_mul;
    t_word            w_key_word;
    t_word            w_seed_next;
    t_word            w_mix_word;
    t_word            w_finish_word;
    t_word            w_head_sel;
    logic [IDX_W-1:0] w_idx_next;
    logic             w_j_last;

    mtg_key_store #(
        .KEY_MAX (KEY_MAX)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_key_count[KAW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_j),
        .o_rdata (w_key_rdata)
    );

    assign w_start_seed = i_take && ((i_opcode == OP_GENERATE && !r_seeded)
                                     || i_opcode == OP_SEED_VALUE
                                     || i_opcode == OP_SEED_KEY);
    assign w_seed_word  = (i_opcode == OP_SEED_VALUE) ? i_value :
                          (i_opcode == OP_SEED_KEY)   ? KEY_BASE_SEED : DEFAULT_SEED;
    assign w_twist      = twist(i_taps.head, i_taps.next, i_taps.far);
    assign w_mul_const  = (r_state == ST_SEED)    ? SEED_MULT :
                          (r_state == ST_KEY_MIX) ? KEY_MULT_A : KEY_MULT_B;
    assign w_mul        = mul32(fold30(r_prev), w_mul_const);
    assign w_key_word   = r_key_zero ? '0 : w_key_rdata;
    assign w_seed_next  = r_prod + WORD_W'(r_cnt);
    assign w_mix_word   = (i_taps.head ^ r_prod) + w_key_word + WORD_W'(r_j);
    assign w_finish_word = (i_taps.head ^ r_prod) - WORD_W'(r_idx);
    assign w_head_sel   = r_first ? i_taps.head : r_prev;
    assign w_idx_next   = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
    assign w_j_last     = (KCW'(r_j) + KCW'(1)) == r_key_len;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start_seed) begin
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                if (r_phase && r_cnt == LAST_IDX) begin
                    if (r_key_mode) begin
                        n_state = ST_KEY_MIX;
                    end else if (r_gen_pending) begin
                        n_state = ST_GEN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_KEY_MIX: begin
                if (r_idx != '0 && r_phase && r_cnt == LAST_IDX) begin
                    n_state = ST_KEY_FINISH;
                end
            end
            ST_KEY_FINISH: begin
                if (r_idx != '0 && r_phase && r_cnt == FINISH_LAST) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (r_first && r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_GEN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_seeded      = r_seeded;
        n_gen_pending = r_gen_pending;
        n_key_mode    = r_key_mode;
        n_first       = r_first;
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_idx         = r_idx;
        n_prev        = r_prev;
        n_prod        = r_prod;
        n_key_count   = r_key_count;
        n_key_len     = r_key_len;
        n_key_zero    = r_key_zero;
        n_j           = r_j;
        w_key_we      = 1'b0;
        o_ring.shift  = 1'b0;
        o_ring.word   = i_taps.head;
        o_gen.valid   = 1'b0;
        o_gen.word    = temper(w_twist);
        case (r_state)
            ST_IDLE: begin
                if (w_start_seed) begin
                    // word 0 of the seed enters the chain right away
                    o_ring.shift  = 1'b1;
                    o_ring.word   = w_seed_word;
                    n_prev        = w_seed_word;
                    n_cnt         = IDX_W'(1);
                    n_phase       = 1'b0;
                    n_gen_pending = (i_opcode == OP_GENERATE);
                    n_key_mode    = (i_opcode == OP_SEED_KEY);
                    if (i_opcode == OP_SEED_KEY) begin
                        n_key_zero  = (r_key_count == '0);
                        n_key_len   = (r_key_count == '0) ? KCW'(1) : r_key_count;
                        n_key_count = '0;
                    end
                end else if (i_take && i_opcode == OP_GENERATE) begin
                    o_ring.shift = 1'b1;
                    o_ring.word  = w_twist;
                    o_gen.valid  = 1'b1;
                end else if (i_take && i_opcode == OP_PUSH_KEY) begin
                    if (r_key_count < KCW'(KEY_MAX)) begin
                        w_key_we    = 1'b1;
                        n_key_count = r_key_count + KCW'(1);
                    end
                end
            end
            ST_SEED: begin
                if (!r_phase) begin
                    n_prod  = w_mul;
                    n_phase = 1'b1;
                end else begin
                    o_ring.shift = 1'b1;
                    o_ring.word  = w_seed_next;
                    n_prev       = w_seed_next;
                    n_cnt        = r_cnt + IDX_W'(1);
                    n_phase      = 1'b0;
                    if (r_cnt == LAST_IDX) begin
                        n_seeded = 1'b1;
                        n_cnt    = '0;
                        n_idx    = '0;
                        n_first  = 1'b1;
                        n_j      = '0;
                    end
                end
            end
            ST_KEY_MIX: begin
                if (r_idx == '0) begin
                    // word 0 is kept on the first pass, then copies the last word
                    o_ring.shift = 1'b1;
                    o_ring.word  = w_head_sel;
                    n_prev       = w_head_sel;
                    n_first      = 1'b0;
                    n_idx        = w_idx_next;
                end else if (!r_phase) begin
                    n_prod  = w_mul;
                    n_phase = 1'b1;
                end else begin
                    o_ring.shift = 1'b1;
                    o_ring.word  = w_mix_word;
                    n_prev       = w_mix_word;
                    n_idx        = w_idx_next;
                    n_phase      = 1'b0;
                    n_j          = w_j_last ? '0 : r_j + KAW'(1);
                    n_cnt        = (r_cnt == LAST_IDX) ? '0 : r_cnt + IDX_W'(1);
                end
            end
            ST_KEY_FINISH: begin
                if (r_idx == '0) begin
                    o_ring.shift = 1'b1;
                    o_ring.word  = r_prev;
                    n_idx        = w_idx_next;
                end else if (!r_phase) begin
                    n_prod  = w_mul;
                    n_phase = 1'b1;
                end else begin
                    o_ring.shift = 1'b1;
                    o_ring.word  = w_finish_word;
                    n_prev       = w_finish_word;
                    n_idx        = w_idx_next;
                    n_phase      = 1'b0;
                    n_cnt        = r_cnt + IDX_W'(1);
                end
            end
            ST_ALIGN: begin
                // one lap to force word 0, then on until word 0 is at the head
                o_ring.shift = 1'b1;
                n_idx        = w_idx_next;
                if (r_idx == '0) begin
                    o_ring.word = HIGH_BIT;
                    n_first     = 1'b1;
                end
            end
            ST_GEN: begin
                o_ring.shift  = 1'b1;
                o_ring.word   = w_twist;
                o_gen.valid   = 1'b1;
                n_gen_pending = 1'b0;
            end
            default: begin
                n_gen_pending = 1'b0;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_seeded      <= 1'b0;
            r_gen_pending <= 1'b0;
            r_key_mode    <= 1'b0;
            r_first       <= 1'b0;
            r_phase       <= 1'b0;
            r_cnt         <= '0;
            r_idx         <= '0;
            r_key_count   <= '0;
            r_key_len     <= '0;
            r_key_zero    <= 1'b0;
            r_j           <= '0;
        end else begin
            r_state       <= n_state;
            r_seeded      <= n_seeded;
            r_gen_pending <= n_gen_pending;
            r_key_mode    <= n_key_mode;
            r_first       <= n_first;
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_idx         <= n_idx;
            r_key_count   <= n_key_count;
            r_key_len     <= n_key_len;
            r_key_zero    <= n_key_zero;
            r_j           <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_prod <= n_prod;
    end

`ifndef ASSERT_OFF
    a_gen_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gen.valid |-> r_seeded)
        else $error("word generated from a state that was never seeded");

    a_key_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KCW'(KEY_MAX))
        else $error("key count beyond key capacity");

    a_key_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KEY_MIX) |-> (r_key_len != '0 && KCW'(r_j) < r_key_len))
        else $error("key index outside key length during mixing");
`endif

endmodule

// ----- design/mersenne_twister_generator.sv -----
`timescale 1ns / 1ps
// 32-bit MT19937 generator built as a chain of 624 word cells that rotates one position per
// step; each generate request twists the head word on the spot, so generate transfers may
// follow back to back while the two-entry output queue has room, and the next request is
// taken while a word still waits. Seeding from a value computes each word with one shared
// 32x32 multiplier with a register after it, then adds it into the chain tail; the first
// generate after reset seeds with 5489 first. Seeding from the key runs value seeding, 624
// key mixing steps, 623 final mixing steps and a final rotation of the chain to put the
// forced top word in place and bring word 0 back to the head. No input is taken while
// seeding runs; key words are pushed while the generator is idle.
module mersenne_twister_generator
    import mtg_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtg_in_if.sink    i_in,
    mtg_out_if.source o_out
);

    logic       w_idle;
    logic       w_take;
    logic       w_pop;
    t_ring_ctl  w_ring;
    t_ring_taps w_taps;
    t_gen_push  w_gen;

    logic  r_out_valid,  n_out_valid;
    t_word r_out_data,   n_out_data;
    logic  r_skid_valid, n_skid_valid;
    t_word r_skid_data,  n_skid_data;

    assign i_in.ready = w_idle && !r_skid_valid;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_pop      = r_out_valid && o_out.ready;

    mtg_seq #(
        .KEY_MAX (KEY_MAX)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_opcode (t_opcode'(i_in.opcode)),
        .i_value  (i_in.value),
        .i_taps   (w_taps),
        .o_idle   (w_idle),
        .o_ring   (w_ring),
        .o_gen    (w_gen)
    );

    mtg_ring u_ring (
        .i_clk  (i_clk),
        .i_ctl  (w_ring),
        .o_taps (w_taps)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = w_gen.valid;
                n_skid_data  = w_gen.word;
            end else begin
                n_out_valid = w_gen.valid;
                n_out_data  = w_gen.word;
            end
        end else if (w_gen.valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_gen.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.random_word = r_out_data;

`ifndef ASSERT_OFF
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("second queue entry held without a first");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gen.valid |-> !r_skid_valid)
        else $error("generated word pushed into a full output queue");
`endif

endmodule
